>>> hw/rtl/iema_pkg.sv
package iema_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TYPE_W      = 5;
  localparam int CODE_W      = 10;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TYPE_W-1:0] EVT_SYN = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] EVT_KEY = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] EVT_REL = TYPE_W'(2);
  localparam logic [TYPE_W-1:0] EVT_ABS = TYPE_W'(3);

  localparam logic [CODE_W-1:0] SYNC_FLUSH = CODE_W'(0);
  localparam logic [CODE_W-1:0] AXIS_X     = CODE_W'(0);
  localparam logic [CODE_W-1:0] AXIS_Y     = CODE_W'(1);
  localparam logic [CODE_W-1:0] MISC_BASE  = CODE_W'(256);
  localparam logic [CODE_W-1:0] BTN_FIRST  = CODE_W'(272);
  localparam logic [CODE_W-1:0] BTN_LAST   = CODE_W'(279);

  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_EN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REL_EN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_EN  = CFG_IDX_W'(2);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [VALUE_WIDTH:0]   wide_t;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_MOTION = 2'd2
  } kind_t;

  // One queued item: first result in full, optional second motion result
  typedef struct packed {
    kind_t               kind;
    logic [CODE_W-1:0]   code;
    logic                pressed;
    value_t              dx;
    value_t              dy;
    logic                two;
    value_t              dx1;
    value_t              dy1;
  } rec_t;

  function automatic value_t sat_wide(input wide_t s);
    value_t r;
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      r = s[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                         : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else begin
      r = s[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/iema_front.sv
module iema_front
  import iema_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TYPE_W-1:0]    in_event_type,
  input  logic [CODE_W-1:0]    in_event_code,
  input  value_t               in_event_value,
  input  logic                 q_full,
  output logic                 push,
  output rec_t                 push_rec
);

  logic   keys_en_r, rel_en_r, abs_en_r;
  value_t sum_x_r, sum_y_r, now_x_r, now_y_r, prev_x_r, prev_y_r;
  logic   pend_r, prev_valid_r;

  value_t sum_x_nxt, sum_y_nxt, now_x_nxt, now_y_nxt, prev_x_nxt, prev_y_nxt;
  logic   pend_nxt, prev_valid_nxt;

  logic   accept, is01, key_hit, btn_hit, sync, rel_emit, abs_flush, abs_emit;
  value_t add_x, add_y, adx, ady;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is01    = (in_event_value == '0) || (in_event_value == value_t'(1));
  assign key_hit = (in_event_type == EVT_KEY) && keys_en_r &&
                   (in_event_code < MISC_BASE) && is01;
  assign btn_hit = (in_event_type == EVT_KEY) && !key_hit && (rel_en_r || abs_en_r) &&
                   (in_event_code >= BTN_FIRST) && (in_event_code <= BTN_LAST) && is01;

  assign add_x = sat_wide(wide_t'(sum_x_r) + wide_t'(in_event_value));
  assign add_y = sat_wide(wide_t'(sum_y_r) + wide_t'(in_event_value));
  assign adx   = sat_wide(wide_t'(now_x_r) - wide_t'(prev_x_r));
  assign ady   = sat_wide(wide_t'(now_y_r) - wide_t'(prev_y_r));

  assign sync      = (in_event_type == EVT_SYN) && (in_event_code == SYNC_FLUSH);
  assign rel_emit  = sync && rel_en_r && ((sum_x_r != '0) || (sum_y_r != '0));
  assign abs_flush = sync && abs_en_r && pend_r;
  // absolute delta only once a previous position exists, and only if nonzero
  assign abs_emit  = abs_flush && prev_valid_r && ((adx != '0) || (ady != '0));

  assign push = accept && (key_hit || btn_hit || rel_emit || abs_emit);

  always_comb begin
    push_rec         = '0;
    push_rec.kind    = KIND_MOTION;
    if (key_hit || btn_hit) begin
      push_rec.kind    = key_hit ? KIND_KEY : KIND_BUTTON;
      push_rec.code    = in_event_code;
      push_rec.pressed = in_event_value[0];
    end else if (rel_emit) begin
      push_rec.dx  = sum_x_r;
      push_rec.dy  = sum_y_r;
      push_rec.two = abs_emit;
      push_rec.dx1 = adx;
      push_rec.dy1 = ady;
    end else begin
      push_rec.dx = adx;
      push_rec.dy = ady;
    end
  end

  always_comb begin
    sum_x_nxt      = sum_x_r;
    sum_y_nxt      = sum_y_r;
    now_x_nxt      = now_x_r;
    now_y_nxt      = now_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    pend_nxt       = pend_r;
    prev_valid_nxt = prev_valid_r;
    if (accept) begin
      if ((in_event_type == EVT_REL) && rel_en_r) begin
        if (in_event_code == AXIS_X) sum_x_nxt = add_x;
        if (in_event_code == AXIS_Y) sum_y_nxt = add_y;
      end
      if ((in_event_type == EVT_ABS) && abs_en_r) begin
        if (in_event_code == AXIS_X) begin
          now_x_nxt = in_event_value;
          pend_nxt  = 1'b1;
        end
        if (in_event_code == AXIS_Y) begin
          now_y_nxt = in_event_value;
          pend_nxt  = 1'b1;
        end
      end
      if (rel_emit) begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
      end
      if (abs_flush) begin
        prev_x_nxt     = now_x_r;
        prev_y_nxt     = now_y_r;
        prev_valid_nxt = 1'b1;
        pend_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_en_r    <= 1'b0;
      rel_en_r     <= 1'b0;
      abs_en_r     <= 1'b0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      now_x_r      <= '0;
      now_y_r      <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      pend_r       <= 1'b0;
      prev_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEYS_EN) keys_en_r <= cfg_wdata;
        if (cfg_index == CFG_REL_EN)  rel_en_r  <= cfg_wdata;
        if (cfg_index == CFG_ABS_EN)  abs_en_r  <= cfg_wdata;
      end
      sum_x_r      <= sum_x_nxt;
      sum_y_r      <= sum_y_nxt;
      now_x_r      <= now_x_nxt;
      now_y_r      <= now_y_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      pend_r       <= pend_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/iema_queue.sv
module iema_queue
  import iema_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output logic full,
  output logic empty,
  output rec_t head
);

  rec_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic [QUEUE_AW-1:0] wr_ptr_nxt, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_nxt;

  assign full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QUEUE_AW'((QUEUE_AW+1)'(wr_ptr_r) + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QUEUE_AW'((QUEUE_AW+1)'(rd_ptr_r) + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

>>> hw/rtl/iema_back.sv
module iema_back
  import iema_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  rec_t              head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_result_kind,
  output logic [CODE_W-1:0] out_key_code,
  output logic              out_pressed,
  output value_t            out_delta_x,
  output value_t            out_delta_y,
  output logic              out_last_of_run
);

  logic              valid_r, sel_r;
  kind_t             kind_r;
  logic [CODE_W-1:0] code_r;
  logic              pressed_r, last_r;
  value_t            dx_r, dy_r;

  logic              load, take, sel_nxt;

  assign load = !valid_r || !out_stall;
  assign take = load && !q_empty;
  // a two-result item stays at the head until its second result goes out
  assign pop  = take && (!head.two || sel_r);

  always_comb begin
    sel_nxt = sel_r;
    if (take) sel_nxt = pop ? 1'b0 : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r    <= head.kind;
      code_r    <= sel_r ? '0 : head.code;
      pressed_r <= sel_r ? 1'b0 : head.pressed;
      dx_r      <= sel_r ? head.dx1 : head.dx;
      dy_r      <= sel_r ? head.dy1 : head.dy;
      last_r    <= pop;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_key_code    = code_r;
  assign out_pressed     = pressed_r;
  assign out_delta_x     = dx_r;
  assign out_delta_y     = dy_r;
  assign out_last_of_run = last_r;

endmodule

>>> hw/rtl/input_event_motion_aggregator.sv
// Input event motion aggregator for one device.
// Input channel: in_valid/in_stall with event type, code and signed value; an
// item is taken at a clock edge with in_valid high and in_stall low. Keys,
// pointer buttons and flushed motion come out on out_valid/out_stall, one
// result per cycle while out_stall is low, out_last_of_run marking the last
// result of an item. Configuration: cfg_we with cfg_index (0 keys,
// 1 relative, 2 absolute) and cfg_wdata, written while the block is idle.
// Throughput: one item per cycle while the queue is not full. The front end
// classifies the item and updates the sums and positions in the cycle it is
// taken; results enter a four-entry queue and the output register drains it.
// A report that flushes both relative and absolute motion gives two results
// from one queue entry, kept at the head until its second result goes out.
// in_stall rises only when the queue is full, i.e. when the receiver has held
// out_stall long enough to back it up; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears the enables, sums, latched positions,
// the queue and the output valid flag.
module input_event_motion_aggregator
  import iema_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TYPE_W-1:0]    in_event_type,
  input  logic [CODE_W-1:0]    in_event_code,
  input  value_t               in_event_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_result_kind,
  output logic [CODE_W-1:0]    out_key_code,
  output logic                 out_pressed,
  output value_t               out_delta_x,
  output value_t               out_delta_y,
  output logic                 out_last_of_run
);

  logic q_full, q_empty, push, pop;
  rec_t push_rec, head;

  iema_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .q_full         (q_full),
    .push           (push),
    .push_rec       (push_rec)
  );

  iema_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  iema_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_key_code    (out_key_code),
    .out_pressed     (out_pressed),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import iema_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic              pressed;
    value_t            dx;
    value_t            dy;
    logic              last;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_wdata = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TYPE_W-1:0]    in_event_type = '0;
  logic [CODE_W-1:0]    in_event_code = '0;
  value_t               in_event_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_result_kind;
  logic [CODE_W-1:0]    out_key_code;
  logic                 out_pressed;
  value_t               out_delta_x;
  value_t               out_delta_y;
  logic                 out_last_of_run;

  // mirror of the block's enables and motion state
  bit     keys_on, rel_on, abs_on;
  value_t rel_x = '0, rel_y = '0, pos_x = '0, pos_y = '0, prev_x = '0, prev_y = '0;
  bit     pos_dirty, prev_known;

  result_t due_results[$];
  int      errors = 0;
  int      cycles = 0;
  int      stall_left = 0;
  bit      gaps_on, stalls_on;

  input_event_motion_aggregator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_event_type   (in_event_type),
    .in_event_code   (in_event_code),
    .in_event_value  (in_event_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_key_code    (out_key_code),
    .out_pressed     (out_pressed),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic value_t clamp_value(longint s);
    if (s > longint'(VAL_MAX)) return VAL_MAX;
    if (s < longint'(VAL_MIN)) return VAL_MIN;
    return value_t'(s);
  endfunction

  // Update the mirrored state for one accepted event and queue what it yields
  function automatic void fold_event(logic [TYPE_W-1:0] ty, logic [CODE_W-1:0] cd,
                                     value_t v);
    result_t made[$];
    result_t r;
    bit      level;
    value_t  dx, dy;
    level = (v == 0) || (v == 1);
    r = '{KIND_KEY, CODE_W'(0), 1'b0, value_t'(0), value_t'(0), 1'b0};
    case (ty)
      EVT_KEY: begin
        if (keys_on && cd < MISC_BASE && level) begin
          r.kind = KIND_KEY;
          r.code = cd;
          r.pressed = v[0];
          made.push_back(r);
        end else if ((rel_on || abs_on) && cd >= BTN_FIRST && cd <= BTN_LAST && level) begin
          r.kind = KIND_BUTTON;
          r.code = cd;
          r.pressed = v[0];
          made.push_back(r);
        end
      end
      EVT_REL: begin
        if (rel_on) begin
          if (cd == AXIS_X) rel_x = clamp_value(longint'(rel_x) + longint'(v));
          else if (cd == AXIS_Y) rel_y = clamp_value(longint'(rel_y) + longint'(v));
        end
      end
      EVT_ABS: begin
        if (abs_on) begin
          if (cd == AXIS_X) begin
            pos_x = v;
            pos_dirty = 1'b1;
          end else if (cd == AXIS_Y) begin
            pos_y = v;
            pos_dirty = 1'b1;
          end
        end
      end
      EVT_SYN: begin
        if (cd == SYNC_FLUSH) begin
          r.kind = KIND_MOTION;
          if (rel_on && (rel_x != 0 || rel_y != 0)) begin
            r.dx = rel_x;
            r.dy = rel_y;
            made.push_back(r);
            rel_x = '0;
            rel_y = '0;
          end
          if (abs_on && pos_dirty) begin
            // first position only seeds the reference point
            if (prev_known) begin
              dx = clamp_value(longint'(pos_x) - longint'(prev_x));
              dy = clamp_value(longint'(pos_y) - longint'(prev_y));
              if (dx != 0 || dy != 0) begin
                r.dx = dx;
                r.dy = dy;
                made.push_back(r);
              end
            end
            prev_x = pos_x;
            prev_y = pos_y;
            prev_known = 1'b1;
            pos_dirty = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (made.size() != 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) due_results.push_back(made[i]);
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d code %0d dx %0d dy %0d",
                 $time, out_result_kind, out_key_code, out_delta_x, out_delta_y);
      end else begin
        want = due_results.pop_front();
        check_field("result_kind", want.kind, out_result_kind);
        check_field("key_code", want.code, out_key_code);
        check_field("pressed", want.pressed, out_pressed);
        check_field("delta_x", want.dx, out_delta_x);
        check_field("delta_y", want.dy, out_delta_y);
        check_field("last_of_run", want.last, out_last_of_run);
      end
    end
    // receiver back-pressure in random bursts
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(logic [TYPE_W-1:0] ty, logic [CODE_W-1:0] cd, value_t v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_event_type <= ty;
    in_event_code <= cd;
    in_event_value <= v;
    do @(posedge clk); while (in_stall);
    fold_event(ty, cd, v);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    // items with no result may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit b);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEYS_EN: keys_on = b;
      CFG_REL_EN:  rel_on = b;
      CFG_ABS_EN:  abs_on = b;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_modes(bit k, bit r, bit a);
    write_reg(CFG_KEYS_EN, k);
    write_reg(CFG_REL_EN, r);
    write_reg(CFG_ABS_EN, a);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 6))
      0:       return value_t'($urandom_range(0, 1));
      1, 2:    return value_t'(int'($urandom_range(0, 32)) - 16);
      3:       return value_t'(int'($urandom_range(0, 4000)) - 2000);
      5:       return $urandom_range(0, 1) ? VAL_MAX - value_t'($urandom_range(0, 2))
                                           : VAL_MIN + value_t'($urandom_range(0, 2));
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_key_code();
    case ($urandom_range(0, 2))
      0:       return CODE_W'($urandom_range(0, 255));
      1:       return CODE_W'($urandom_range(BTN_FIRST, BTN_LAST));
      default: return CODE_W'($urandom_range(0, 767));
    endcase
  endfunction

  function automatic value_t pick_key_state();
    if ($urandom_range(0, 7) == 0) return pick_value();
    return value_t'($urandom_range(0, 1));
  endfunction

  // nothing enabled: every event is dropped
  task automatic test_all_disabled();
    set_modes(1'b0, 1'b0, 1'b0);
    send_event(EVT_KEY, 10'd5, 1);
    send_event(EVT_KEY, BTN_FIRST, 1);
    send_event(EVT_REL, AXIS_X, 7);
    send_event(EVT_ABS, AXIS_X, 9);
    send_event(EVT_SYN, SYNC_FLUSH, 0);
  endtask

  task automatic test_keys_and_buttons();
    set_modes(1'b1, 1'b1, 1'b0);
    send_event(EVT_KEY, 10'd0, 1);
    send_event(EVT_KEY, CODE_W'(MISC_BASE - 1), 0);
    send_event(EVT_KEY, MISC_BASE, 1);
    send_event(EVT_KEY, BTN_FIRST, 1);
    send_event(EVT_KEY, BTN_LAST, 0);
    send_event(EVT_KEY, CODE_W'(BTN_LAST + 1), 1);
    send_event(EVT_KEY, 10'd30, 2);     // autorepeat
    send_event(EVT_KEY, 10'd30, -1);
    send_event(EVT_KEY, 10'd767, 1);
    set_modes(1'b0, 1'b0, 1'b1);
    send_event(EVT_KEY, 10'd100, 1);
    send_event(EVT_KEY, 10'd275, 1);
  endtask

  task automatic test_motion_flush();
    set_modes(1'b1, 1'b1, 1'b1);
    send_event(EVT_REL, AXIS_X, VAL_MAX);
    send_event(EVT_REL, AXIS_X, 5);     // sum clips high
    send_event(EVT_REL, AXIS_Y, VAL_MIN);
    send_event(EVT_REL, AXIS_Y, -1);    // sum clips low
    send_event(EVT_ABS, AXIS_X, VAL_MIN);
    send_event(EVT_ABS, AXIS_Y, 0);
    send_event(EVT_SYN, SYNC_FLUSH, 0); // relative only, no previous position yet
    send_event(EVT_ABS, AXIS_X, VAL_MAX);
    send_event(EVT_ABS, AXIS_Y, VAL_MAX);
    send_event(EVT_SYN, SYNC_FLUSH, 0); // delta clips
    send_event(EVT_ABS, AXIS_X, VAL_MAX);
    send_event(EVT_SYN, SYNC_FLUSH, 0); // zero delta
    send_event(EVT_REL, 10'd2, 3);
    send_event(EVT_ABS, 10'd5, 3);
    send_event(EVT_SYN, 10'd1, 0);
    send_event(5'd4, 10'd0, 1);
    send_event(5'd31, 10'd1023, -1);
    send_event(EVT_REL, AXIS_X, 3);
    send_event(EVT_ABS, AXIS_Y, 10);
    send_event(EVT_SYN, SYNC_FLUSH, 0); // both flushes
  endtask

  // a mode switched off across a report keeps its pending motion
  task automatic test_pending_kept();
    set_modes(1'b0, 1'b1, 1'b1);
    send_event(EVT_REL, AXIS_X, 4);
    send_event(EVT_ABS, AXIS_X, 20);
    write_reg(CFG_REL_EN, 1'b0);
    write_reg(CFG_ABS_EN, 1'b0);
    send_event(EVT_SYN, SYNC_FLUSH, 0);
    write_reg(CFG_REL_EN, 1'b1);
    write_reg(CFG_ABS_EN, 1'b1);
    send_event(EVT_SYN, SYNC_FLUSH, 0);
  endtask

  task automatic run_random(int n);
    int                sent;
    int                parts;
    logic [TYPE_W-1:0] ty;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        parts = $urandom_range(1, 4);
        repeat (parts) begin
          case ($urandom_range(0, 3))
            0:       send_event(EVT_REL, $urandom_range(0, 1) ? AXIS_Y : AXIS_X, pick_value());
            1:       send_event(EVT_ABS, $urandom_range(0, 1) ? AXIS_Y : AXIS_X, pick_value());
            default: send_event(EVT_KEY, pick_key_code(), pick_key_state());
          endcase
        end
        send_event(EVT_SYN, SYNC_FLUSH, pick_value());
        sent += parts + 1;
      end else begin
        ty = $urandom_range(0, 1) ? TYPE_W'($urandom_range(0, 3)) : TYPE_W'($urandom);
        send_event(ty, CODE_W'($urandom_range(0, 767)), value_t'($urandom));
        if (ty <= EVT_ABS) sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    bit [2:0] modes[8] = '{3'b111, 3'b000, 3'b100, 3'b010, 3'b001, 3'b011, 3'b110, 3'b101};
    foreach (modes[i]) begin
      set_modes(modes[i][2], modes[i][1], modes[i][0]);
      run_random(70);
    end
    // closing stretch at full rate
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_modes(1'b1, 1'b1, 1'b1);
    run_random(90);
  endtask

  initial begin : main
    int drain;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_all_disabled();
    test_keys_and_buttons();
    test_motion_flush();
    test_pending_kept();
    test_random_traffic();
    in_valid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (due_results.size() != 0 && drain < 1000);
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      errors += due_results.size();
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/iema_pkg.sv
hw/rtl/iema_front.sv
hw/rtl/iema_queue.sv
hw/rtl/iema_back.sv
hw/rtl/input_event_motion_aggregator.sv
dv/tb_top.sv
